>>> hw/rtl/rrtp_pkg.sv
// Shared types and constants for the round-robin thread picker.
`timescale 1ns / 1ps
`default_nettype none
package rrtp_pkg;
  localparam int MAX_THREADS = 64;
  localparam int NUM_SLOTS = 64;
  localparam int LIST_CAP = (MAX_THREADS < NUM_SLOTS) ? MAX_THREADS : NUM_SLOTS;
  localparam int SLOT_W = 6;
  localparam int CNT_W = (LIST_CAP > 1) ? $clog2(LIST_CAP) : 1;
  localparam int TICK_W = 64;
  localparam int OP_W = 3;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_SLEEP  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_SWITCH = 3'd4;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PASS  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;
endpackage
`default_nettype wire

>>> hw/rtl/round_robin_thread_picker.sv
// Top level of the round-robin thread picker with wake deadlines.
// The one-cycle out_valid strobe of a request comes after one full rotation of the
// list cell chain in ST_PASS, which streams each entry past the head once while a wake
// tick is read per cycle, then ST_DRAIN to check the last entry, then the strobe in
// ST_FIN. The next request can be accepted only once the picker is back in ST_IDLE.
// Busy stays high until the strobe cycle ends; the result cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
module round_robin_thread_picker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire  [rrtp_pkg::OP_W-1:0]        in_op,
  input  wire  [rrtp_pkg::SLOT_W-1:0]      in_slot,
  input  wire                              in_has_current,
  input  wire  [rrtp_pkg::TICK_W-1:0]      in_deadline,
  input  wire  [rrtp_pkg::TICK_W-1:0]      in_now,
  output logic                             out_valid,
  output logic                             out_picked,
  output logic [rrtp_pkg::SLOT_W-1:0]      out_picked_slot
);
  import rrtp_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(LIST_CAP - 1);

  state_t              state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [OP_W-1:0]     op_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                has_cur_r;
  logic [TICK_W-1:0]   now_r;
  logic                dropped_r;
  logic                app_pend_r;
  logic                chk_valid_r;
  logic [SLOT_W-1:0]   chk_slot_r;
  logic [TICK_W-1:0]   wake_q_r;
  logic                found_r;
  logic [SLOT_W-1:0]   pick_r;
  logic [NUM_SLOTS-1:0] run_r;
  logic [TICK_W-1:0]   wake_mem [NUM_SLOTS];

  entry_t cell_q [LIST_CAP];
  entry_t push;
  entry_t cand;
  logic   accept;
  logic   in_pass;
  logic   is_switch_op;
  logic   move_en;
  logic   drop_en;
  logic   match0;
  logic   drop_now;
  logic   use_next;
  logic   pend_now;
  logic   do_append;
  logic   hit;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  logic [TICK_W-1:0]   wr_data;

  genvar gi;
  generate
    for (gi = 0; gi < LIST_CAP; gi++) begin : g_cell
      entry_t d_in;
      if (gi == LIST_CAP - 1) begin : g_tail
        assign d_in = push;
      end else begin : g_mid
        assign d_in = cell_q[gi+1];
      end
      rrtp_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (in_pass),
        .d_in     (d_in),
        .q        (cell_q[gi])
      );
    end
  endgenerate

  assign busy = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign in_pass = (state_r == ST_PASS);
  assign is_switch_op = (op_r == OP_SLEEP) || (op_r == OP_SWITCH);
  assign move_en = is_switch_op && has_cur_r;
  assign drop_en = move_en || (op_r == OP_REMOVE);
  assign match0 = cell_q[0].valid && (cell_q[0].slot == slot_r);
  assign drop_now = in_pass && drop_en && !dropped_r && match0;
  assign use_next = dropped_r || drop_now;

  always_comb begin
    if (use_next) begin
      cand = (cnt_r == LAST) ? '0 : cell_q[1 % LIST_CAP];
    end else begin
      cand = cell_q[0];
    end
    pend_now = (app_pend_r || (drop_now && move_en)) && !((op_r == OP_ADD) && match0);
    do_append = in_pass && !cand.valid && pend_now;
    if (do_append) begin
      push.valid = 1'b1;
      push.slot = slot_r;
    end else begin
      push = cand;
    end
  end

  assign hit = chk_valid_r && !found_r && !run_r[chk_slot_r] && (wake_q_r <= now_r);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = in_slot;
    wr_data = '0;
    if (accept && (in_op == OP_SLEEP) && in_has_current) begin
      wr_en = 1'b1;
      wr_data = in_deadline;
    end else if (accept && (in_op == OP_CLEAR)) begin
      wr_en = 1'b1;
    end else if (do_append && (op_r == OP_ADD)) begin
      wr_en = 1'b1;
      wr_addr = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wake_mem[wr_addr] <= wr_data;
    end
    wake_q_r <= wake_mem[push.slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      dropped_r <= 1'b0;
      app_pend_r <= 1'b0;
      chk_valid_r <= 1'b0;
      found_r <= 1'b0;
      pick_r <= '0;
      run_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r <= in_op;
            slot_r <= in_slot;
            has_cur_r <= in_has_current;
            now_r <= in_now;
            cnt_r <= '0;
            dropped_r <= 1'b0;
            app_pend_r <= (in_op == OP_ADD);
            chk_valid_r <= 1'b0;
            found_r <= 1'b0;
            pick_r <= '0;
            if (((in_op == OP_SLEEP) || (in_op == OP_SWITCH)) && in_has_current) begin
              run_r[in_slot] <= 1'b0;
            end
            state_r <= ST_PASS;
          end
        end
        ST_PASS: begin
          dropped_r <= use_next;
          app_pend_r <= pend_now && !do_append;
          chk_valid_r <= push.valid && is_switch_op;
          chk_slot_r <= push.slot;
          if (hit) begin
            found_r <= 1'b1;
            pick_r <= chk_slot_r;
            run_r[chk_slot_r] <= 1'b1;
          end else if ((drop_now && (op_r == OP_REMOVE)) ||
                       (do_append && (op_r == OP_ADD))) begin
            run_r[slot_r] <= 1'b0;
          end
          if (cnt_r == LAST) begin
            state_r <= ST_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          chk_valid_r <= 1'b0;
          if (hit) begin
            found_r <= 1'b1;
            pick_r <= chk_slot_r;
            run_r[chk_slot_r] <= 1'b1;
          end
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = (state_r == ST_FIN);
  assign out_picked = found_r;
  assign out_picked_slot = pick_r;
endmodule
`default_nettype wire

>>> hw/rtl/rrtp_cell.sv
// One list cell of the picker's rotating order chain.
`timescale 1ns / 1ps
`default_nettype none
module rrtp_cell (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   shift_en,
  input  wire rrtp_pkg::entry_t d_in,
  output rrtp_pkg::entry_t      q
);
  import rrtp_pkg::*;

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (shift_en) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;
endmodule
`default_nettype wire
